// ===== rtl/core/spw_pkg.sv =====
// Shared types and constants of the servo pulse watchdog.
`default_nettype none

package spw_pkg;

   // Field widths.
   localparam int CHAN_W     = 3;
   localparam int PULSE_W    = 16;
   localparam int POS_W      = 16;
   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = 2;

   // Positions are signed Q2.14; one full unit of travel is 1 << 14.
   localparam int POS_FRAC_W = 14;
   localparam int POS_ONE    = 1 << POS_FRAC_W;

   // Only eight channels can be named by the channel field.
   localparam int ADDR_CHANNELS = 1 << CHAN_W;

   typedef logic [CHAN_W-1:0]         chan_type;
   typedef logic [PULSE_W-1:0]        pulse_type;
   typedef logic signed [POS_W-1:0]   position_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic [CSR_IDX_W-1:0]      csr_index_type;

   // Operation codes of an input word.
   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_PULSE_MIN = 2'd0;
   localparam csr_index_type CSR_PULSE_MAX = 2'd1;
   localparam csr_index_type CSR_TIMEOUT   = 2'd2;

   // Register reset values.
   localparam pulse_type RST_PULSE_MIN = 16'd1000;
   localparam pulse_type RST_PULSE_MAX = 16'd2000;
   localparam count_type RST_TIMEOUT   = 16'd10;

   localparam count_type CNT_MAX = {CNT_W{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/core/spw_channel_if.sv =====
// Valid/ready channel interfaces for command words in and pulse words out.
`default_nettype none

interface spw_req_if import spw_pkg::*;;
   logic         valid;
   logic         ready;
   logic         op;
   chan_type     channel;
   logic         present;
   position_type position;
   logic         end_of_command;

   modport source (output valid, op, channel, present, position, end_of_command,
                   input ready);
   modport sink   (input valid, op, channel, present, position, end_of_command,
                   output ready);
endinterface

interface spw_rsp_if import spw_pkg::*;;
   logic      valid;
   logic      ready;
   chan_type  out_channel;
   pulse_type pulse_us;
   logic      last;

   modport source (output valid, out_channel, pulse_us, last, input ready);
   modport sink   (input valid, out_channel, pulse_us, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spw_scaler.sv =====
// Two-step position to pulse width scaler: clamp and multiply, then truncate and offset.
`default_nettype none

module spw_scaler import spw_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire position_type position,
   input  wire pulse_type    pulse_min,
   input  wire pulse_type    pulse_max,
   output logic              done,
   output pulse_type         pulse
);

   localparam int CLAMP_W = POS_FRAC_W + 1;
   localparam int SPAN_W  = PULSE_W + 1;
   localparam int PROD_W  = 32;

   logic [CLAMP_W-1:0]        clamp_pos;
   logic signed [SPAN_W-1:0]  span;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  biased;
   logic signed [PROD_W-1:0]  quot;
   logic                      mul_ff;
   logic                      done_ff;
   pulse_type                 pulse_ff;

   always_comb begin
      if (position[POS_W-1]) begin
         clamp_pos = '0;
      end else if (position > POS_W'(POS_ONE)) begin
         clamp_pos = CLAMP_W'(POS_ONE);
      end else begin
         clamp_pos = position[CLAMP_W-1:0];
      end
   end

   assign span    = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
   // Both factors are sign-extended to the product width before the multiply.
   assign prod_in = PROD_W'($signed({1'b0, clamp_pos})) * PROD_W'(span);

   // Division by 2^14 truncating toward zero: bias negative products first.
   assign biased = prod_ff + (prod_ff[PROD_W-1] ? PROD_W'(POS_ONE - 1) : '0);
   assign quot   = biased >>> POS_FRAC_W;

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
      if (mul_ff) begin
         pulse_ff <= pulse_min + quot[PULSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= start;
         done_ff <= mul_ff;
      end
   end

   assign done  = done_ff;
   assign pulse = pulse_ff;

endmodule

`default_nettype wire

// ===== rtl/core/servo_pulse_watchdog.sv =====
// Servo pulse scaler with a command watchdog: top level and sequencer.
// A command word with a position holds the block through accept, decode, multiply and offset;
// a command that only disables a channel holds it through accept and decode.
// A tick steps through accept, decode and counter update, then one channel per cycle into the
// single output register for min(CHANNELS, 8) channels, held by any result-side stalls.
// Synchronous active-high reset clears enables and tick counter, registers to 1000, 2000, 10.
`default_nettype none

module servo_pulse_watchdog import spw_pkg::*; #(
   parameter int CHANNELS = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   spw_req_if.sink            req_bus,
   spw_rsp_if.source          rsp_bus,
   input  wire logic          csr_we,
   input  wire csr_index_type csr_index,
   input  wire pulse_type     csr_wdata
);

   // Channels beyond what the channel field can name are never reachable, so only
   // the addressable ones get storage.
   localparam int SCAN_N = (CHANNELS < ADDR_CHANNELS) ? CHANNELS : ADDR_CHANNELS;
   localparam int IDX_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SCAN_N - 1);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SCALE  = 3'd2;
   localparam logic [2:0] ST_TICK   = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;

   logic [2:0]        state_ff, state_in;

   // The accepted word is held here while the sequencer works on it.
   logic              op_ff;
   chan_type          chan_ff;
   logic              present_ff;
   position_type      pos_ff;
   logic              eoc_ff;

   // Configuration registers.
   pulse_type         pulse_min_ff;
   pulse_type         pulse_max_ff;
   count_type         timeout_ff;

   // Channel state: enables reset to zero, pulse widths are only read once written.
   logic [SCAN_N-1:0] en_ff, en_in;
   pulse_type         pulse_mem [SCAN_N];
   count_type         cnt_ff, cnt_in;
   count_type         cnt_bump;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   chan_type          rsp_chan_ff;
   pulse_type         rsp_pulse_ff;
   logic              rsp_last_ff;

   logic              accept;
   logic              chan_ok;
   logic [IDX_W-1:0]  chan_idx;
   logic              slot_free;
   logic              scan_hit;
   logic              more_after;
   logic              rsp_load;
   logic              pulse_we;
   logic              scale_start;
   logic              scale_done;
   pulse_type         scale_pulse;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // A command for a channel that does not exist still restarts the watchdog when it ends a command.
   assign chan_ok  = ({1'b0, chan_ff} < (CHAN_W + 1)'(SCAN_N));
   assign chan_idx = chan_ff[IDX_W-1:0];

   // The output register can take a new word when it is empty or being drained.
   assign slot_free  = !rsp_valid_ff || rsp_bus.ready;
   assign scan_hit   = en_ff[idx_ff];
   // The last marker goes on a word when no enabled channel follows it.
   assign more_after = |((en_ff >> idx_ff) >> 1);

   assign cnt_bump = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;

   spw_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .start     (scale_start),
      .position  (pos_ff),
      .pulse_min (pulse_min_ff),
      .pulse_max (pulse_max_ff),
      .done      (scale_done),
      .pulse     (scale_pulse)
   );

   always_comb begin
      state_in     = state_ff;
      en_in        = en_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_load     = 1'b0;
      scale_start  = 1'b0;
      pulse_we     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (op_ff == OP_TICK) begin
               state_in = ST_TICK;
            end else if (present_ff && chan_ok) begin
               scale_start = 1'b1;
               state_in    = ST_SCALE;
            end else begin
               if (chan_ok) begin
                  en_in[chan_idx] = 1'b0;
               end
               if (eoc_ff) begin
                  cnt_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCALE: begin
            // The channel is enabled together with the write of its pulse width.
            if (scale_done) begin
               pulse_we        = 1'b1;
               en_in[chan_idx] = 1'b1;
               if (eoc_ff) begin
                  cnt_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            // The counter saturates; reaching the timeout drops every channel
            // before the pulses of this tick are sent.
            cnt_in = cnt_bump;
            if (cnt_bump >= timeout_ff) begin
               en_in = '0;
            end
            idx_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Disabled channels are passed at once; enabled ones wait for room.
            if (!scan_hit || slot_free) begin
               if (scan_hit) begin
                  rsp_load     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         en_ff        <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pulse_min_ff <= RST_PULSE_MIN;
         pulse_max_ff <= RST_PULSE_MAX;
         timeout_ff   <= RST_TIMEOUT;
      end else begin
         state_ff     <= state_in;
         en_ff        <= en_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PULSE_MIN: pulse_min_ff <= csr_wdata;
               CSR_PULSE_MAX: pulse_max_ff <= csr_wdata;
               CSR_TIMEOUT:   timeout_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_bus.op;
         chan_ff    <= req_bus.channel;
         present_ff <= req_bus.present;
         pos_ff     <= req_bus.position;
         eoc_ff     <= req_bus.end_of_command;
      end
      if (rsp_load) begin
         rsp_chan_ff  <= CHAN_W'(idx_ff);
         rsp_pulse_ff <= pulse_mem[idx_ff];
         rsp_last_ff  <= !more_after;
      end
   end

   always_ff @(posedge clock) begin
      if (pulse_we) begin
         pulse_mem[chan_idx] <= scale_pulse;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_channel = rsp_chan_ff;
   assign rsp_bus.pulse_us    = rsp_pulse_ff;
   assign rsp_bus.last        = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/spw_checker.sv =====
// Port-level assertions for the servo pulse watchdog and their bind.
`default_nettype none

module spw_checker import spw_pkg::*; (
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_ready,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input wire chan_type  rsp_out_channel,
   input wire pulse_type rsp_pulse_us,
   input wire logic      rsp_last
);

   // After reset the block is idle with nothing to send.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // Every input word leaves the sequencer busy once it is accepted.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block ready directly after accepting a word");

   // While a tick still has words to send, no new input word is taken.
   a_busy_mid_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |-> !req_ready)
      else $error("input accepted in the middle of a tick");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_channel)
         && $stable(rsp_pulse_us) && $stable(rsp_last))
      else $error("result word changed while stalled");

endmodule

bind servo_pulse_watchdog spw_checker u_spw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_channel (rsp_bus.out_channel),
   .rsp_pulse_us    (rsp_bus.pulse_us),
   .rsp_last        (rsp_bus.last)
);

`default_nettype wire
